>>> hw/rtl/mccn_pkg.sv
// Shared types and constants for the capability negotiator.
package mccn_pkg;
    localparam logic [1:0] ACT_MAKE    = 2'd0;
    localparam logic [1:0] ACT_VERIFY  = 2'd1;
    localparam logic [1:0] ACT_RESOLVE = 2'd2;

    localparam logic [2:0] REG_KEY_LOW    = 3'd0;
    localparam logic [2:0] REG_KEY_HIGH   = 3'd1;
    localparam logic [2:0] REG_BASELINE   = 3'd2;
    localparam logic [2:0] REG_LEVEL_ONE  = 3'd3;
    localparam logic [2:0] REG_LEVEL_TWO  = 3'd4;
    localparam logic [2:0] REG_LEVEL_THR  = 3'd5;
    localparam logic [2:0] REG_LEVEL_FOUR = 3'd6;

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [31:0] MSG_HDR = 32'h50433348;
    localparam logic [63:0] LEN_WORD = 64'h0800000000000000;

    localparam int NUM_STAGES = 9;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } t_sip;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction

    function automatic t_sip sip_round(input t_sip s);
        t_sip t;
        t = s;
        t.v0 = t.v0 + t.v1; t.v1 = rotl(t.v1, 13); t.v1 = t.v1 ^ t.v0;
        t.v0 = rotl(t.v0, 32);
        t.v2 = t.v2 + t.v3; t.v3 = rotl(t.v3, 16); t.v3 = t.v3 ^ t.v2;
        t.v0 = t.v0 + t.v3; t.v3 = rotl(t.v3, 21); t.v3 = t.v3 ^ t.v0;
        t.v2 = t.v2 + t.v1; t.v1 = rotl(t.v1, 17); t.v1 = t.v1 ^ t.v2;
        t.v2 = rotl(t.v2, 32);
        sip_round = t;
    endfunction

    function automatic logic [63:0] msg_word(input logic [31:0] caps);
        msg_word = {caps[7:0], caps[15:8], caps[23:16], caps[31:24], MSG_HDR};
    endfunction
endpackage

>>> hw/rtl/mac_checked_capability_negotiator.sv
// Capability negotiator top level: SipHash-2-4 checked offers, one round per stage.
// Usage:
//   Input channel i_valid/o_stall carries action, masks and tags; an item is
//   accepted when i_valid is high and o_stall low. Output channel o_valid/i_stall
//   carries offer_caps, offer_tag, agreed_level and status, one result per item.
//   Configuration writes go through i_cfg_valid/o_cfg_ready with an index
//   and 64-bit data; masks take the low 32 bits, unknown indexes are dropped.
//   Throughput: one item per cycle while the receiver does not stall; each of
//   the eight SipHash rounds of both offers is one stage, plus one stage to
//   compare and negotiate.
//   Reset clears all valid bits and loads the register defaults.
//   When the receiver stalls the result holds and the stages behind it close
//   up; the input stalls only once every stage holds an item, so nothing is
//   lost or repeated.
module mac_checked_capability_negotiator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_local_caps,
    input  logic [63:0] i_local_tag,
    input  logic [31:0] i_remote_caps,
    input  logic [63:0] i_remote_tag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_offer_caps,
    output logic [63:0] o_offer_tag,
    output logic [31:0] o_agreed_level,
    output logic        o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import mccn_pkg::*;

    localparam int NR = NUM_STAGES - 1;

    logic [63:0] r_key_low, r_key_high;
    logic [31:0] r_base, r_l1, r_l2, r_l3, r_l4;

    logic            r_vld [NR];
    logic [1:0]      r_act [NR];
    logic [31:0]     r_lc  [NR];
    logic [31:0]     r_rc  [NR];
    logic [63:0]     r_lt  [NR];
    logic [63:0]     r_rt  [NR];
    t_sip            r_sa  [NR];
    t_sip            r_sb  [NR];
    logic [63:0]     r_ma;
    logic [63:0]     r_mb;

    logic            r_out_vld;
    logic [31:0]     r_caps, r_agreed;
    logic [63:0]     r_tag;
    logic            r_status;

    logic            adv [NR + 1];
    t_sip            n_sa [NR];
    t_sip            n_sb [NR];
    logic [31:0]     n_lc;
    t_sip            init_a, init_b;

    logic [31:0]     n_caps, n_agreed;
    logic [63:0]     n_tag;
    logic            n_status;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_vld;
    assign o_offer_caps   = r_caps;
    assign o_offer_tag    = r_tag;
    assign o_agreed_level = r_agreed;
    assign o_status       = r_status;

    always_comb begin
        adv[NR] = !r_out_vld || !i_stall;
        for (int k = NR - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k + 1];
        end
    end
    assign o_stall = !adv[0];

    always_comb begin
        n_lc = (i_action == ACT_MAKE) ? (i_local_caps | r_base) : i_local_caps;
        init_a.v0 = r_key_low ^ SIP_C0;
        init_a.v1 = r_key_high ^ SIP_C1;
        init_a.v2 = r_key_low ^ SIP_C2;
        init_a.v3 = r_key_high ^ SIP_C3 ^ msg_word(n_lc);
        init_b = init_a;
        init_b.v3 = r_key_high ^ SIP_C3 ^ msg_word(i_remote_caps);
        n_sa[0] = sip_round(init_a);
        n_sb[0] = sip_round(init_b);
        for (int k = 1; k < NR; k++) begin
            n_sa[k] = sip_round(r_sa[k - 1]);
            n_sb[k] = sip_round(r_sb[k - 1]);
            if (k == 1) begin
                n_sa[k].v0 = n_sa[k].v0 ^ r_ma;
                n_sa[k].v3 = n_sa[k].v3 ^ LEN_WORD;
                n_sb[k].v0 = n_sb[k].v0 ^ r_mb;
                n_sb[k].v3 = n_sb[k].v3 ^ LEN_WORD;
            end
            if (k == 3) begin
                n_sa[k].v0 = n_sa[k].v0 ^ LEN_WORD;
                n_sa[k].v2 = n_sa[k].v2 ^ 64'hFF;
                n_sb[k].v0 = n_sb[k].v0 ^ LEN_WORD;
                n_sb[k].v2 = n_sb[k].v2 ^ 64'hFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_base <= 32'd1;
            r_l1   <= 32'd1;
            r_l2   <= 32'd2;
            r_l3   <= 32'd4;
            r_l4   <= 32'd8;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY_LOW:    r_key_low  <= i_cfg_data;
                REG_KEY_HIGH:   r_key_high <= i_cfg_data;
                REG_BASELINE:   r_base <= i_cfg_data[31:0];
                REG_LEVEL_ONE:  r_l1   <= i_cfg_data[31:0];
                REG_LEVEL_TWO:  r_l2   <= i_cfg_data[31:0];
                REG_LEVEL_THR:  r_l3   <= i_cfg_data[31:0];
                REG_LEVEL_FOUR: r_l4   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv[0]) begin
            r_vld[0] <= i_valid;
        end
        if (adv[0]) begin
            r_sa[0]  <= n_sa[0];
            r_sb[0]  <= n_sb[0];
            r_act[0] <= i_action;
            r_lc[0]  <= n_lc;
            r_rc[0]  <= i_remote_caps;
            r_lt[0]  <= i_local_tag;
            r_rt[0]  <= i_remote_tag;
            r_ma     <= msg_word(n_lc);
            r_mb     <= msg_word(i_remote_caps);
        end
        for (int k = 1; k < NR; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (adv[k]) begin
                r_vld[k] <= r_vld[k - 1];
            end
            if (adv[k]) begin
                r_sa[k]  <= n_sa[k];
                r_sb[k]  <= n_sb[k];
                r_act[k] <= r_act[k - 1];
                r_lc[k]  <= r_lc[k - 1];
                r_rc[k]  <= r_rc[k - 1];
                r_lt[k]  <= r_lt[k - 1];
                r_rt[k]  <= r_rt[k - 1];
            end
        end
    end

    logic [63:0] mac_a, mac_b;
    logic [31:0] common, level;
    assign mac_a  = r_sa[NR-1].v0 ^ r_sa[NR-1].v1 ^ r_sa[NR-1].v2 ^ r_sa[NR-1].v3;
    assign mac_b  = r_sb[NR-1].v0 ^ r_sb[NR-1].v1 ^ r_sb[NR-1].v2 ^ r_sb[NR-1].v3;
    assign common = r_lc[NR-1] & r_rc[NR-1];
    always_comb begin
        if ((common & r_base) == '0)   level = '0;
        else if ((common & r_l4) != '0) level = r_l4;
        else if ((common & r_l3) != '0) level = r_l3;
        else if ((common & r_l2) != '0) level = r_l2;
        else                            level = r_l1;
    end

    always_comb begin
        n_caps = '0; n_tag = '0; n_agreed = '0; n_status = 1'b0;
        case (r_act[NR-1])
            ACT_MAKE: begin
                n_caps = r_lc[NR-1];
                n_tag  = mac_a;
            end
            ACT_VERIFY: begin
                n_caps   = r_lc[NR-1];
                n_tag    = mac_a;
                n_status = (mac_a != r_lt[NR-1]);
            end
            ACT_RESOLVE: begin
                if (mac_a == r_lt[NR-1] && mac_b == r_rt[NR-1]) begin
                    n_agreed = level;
                end else begin
                    n_status = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv[NR]) begin
            r_out_vld <= r_vld[NR-1];
        end
        if (adv[NR]) begin
            r_caps   <= n_caps;
            r_tag    <= n_tag;
            r_agreed <= n_agreed;
            r_status <= n_status;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_offer_tag) && $stable(o_status))
        else $error("result changed under stall");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_vld[0] && o_valid && i_stall)
        else $error("input stalled with room in pipeline");
    a_make_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_agreed_level == '0)
        else $error("failed check carries a level");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NR-1] && !o_valid |=> o_valid)
        else $error("last stage did not drain");
`endif
endmodule

>>> tb/mccn_checker.sv
// Offer MAC helper and scoreboard that predicts and checks every negotiator result.
package mccn_tb_pkg;
    function automatic logic [63:0] rot64(input logic [63:0] x, input int r);
        rot64 = (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [255:0] sip_mix(input logic [255:0] s);
        logic [63:0] a, b, c, d;
        {a, b, c, d} = s;
        a = a + b; b = rot64(b, 13); b = b ^ a; a = rot64(a, 32);
        c = c + d; d = rot64(d, 16); d = d ^ c;
        a = a + d; d = rot64(d, 21); d = d ^ a;
        c = c + b; b = rot64(b, 17); b = b ^ c; c = rot64(c, 32);
        sip_mix = {a, b, c, d};
    endfunction

    function automatic logic [63:0] caps_sip_tag(input logic [63:0] klo, input logic [63:0] khi,
                                                 input logic [31:0] caps);
        logic [63:0] a, b, c, d, word;
        logic [255:0] s;
        a = klo ^ 64'h736f6d6570736575;
        b = khi ^ 64'h646f72616e646f6d;
        c = klo ^ 64'h6c7967656e657261;
        d = khi ^ 64'h7465646279746573;
        word = {caps[7:0], caps[15:8], caps[23:16], caps[31:24], 8'h50, 8'h43, 8'h33, 8'h48};
        d = d ^ word;
        s = sip_mix(sip_mix({a, b, c, d}));
        {a, b, c, d} = s;
        a = a ^ word;
        d = d ^ {8'h08, 56'h0};
        s = sip_mix(sip_mix({a, b, c, d}));
        {a, b, c, d} = s;
        a = a ^ {8'h08, 56'h0};
        c = c ^ 64'hff;
        s = sip_mix(sip_mix(sip_mix(sip_mix({a, b, c, d}))));
        {a, b, c, d} = s;
        caps_sip_tag = a ^ b ^ c ^ d;
    endfunction
endpackage

module mccn_checker
    import mccn_pkg::*;
    import mccn_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_local_caps,
    input  logic [63:0] i_local_tag,
    input  logic [31:0] i_remote_caps,
    input  logic [63:0] i_remote_tag,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_offer_caps,
    input  logic [63:0] o_offer_tag,
    input  logic [31:0] o_agreed_level,
    input  logic        o_status,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] caps;
        logic [63:0] tag;
        logic [31:0] level;
        logic        status;
    } t_outcome;

    t_outcome    outcome_q[$];
    logic [63:0] key_lo, key_hi;
    logic [31:0] base_m, lvl1_m, lvl2_m, lvl3_m, lvl4_m;

    function automatic logic [31:0] pick_level(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] common;
        common = a & b;
        if ((common & base_m) == 0) return 0;
        if ((common & lvl4_m) != 0) return lvl4_m;
        if ((common & lvl3_m) != 0) return lvl3_m;
        if ((common & lvl2_m) != 0) return lvl2_m;
        return lvl1_m;
    endfunction

    function automatic t_outcome predict_outcome();
        t_outcome r;
        r = '0;
        case (i_action)
            ACT_MAKE: begin
                r.caps = i_local_caps | base_m;
                r.tag = caps_sip_tag(key_lo, key_hi, r.caps);
            end
            ACT_VERIFY: begin
                r.caps = i_local_caps;
                r.tag = caps_sip_tag(key_lo, key_hi, i_local_caps);
                r.status = (r.tag != i_local_tag);
            end
            ACT_RESOLVE: begin
                if (caps_sip_tag(key_lo, key_hi, i_local_caps) == i_local_tag &&
                    caps_sip_tag(key_lo, key_hi, i_remote_caps) == i_remote_tag)
                    r.level = pick_level(i_local_caps, i_remote_caps);
                else
                    r.status = 1'b1;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            key_lo <= '0; key_hi <= '0;
            base_m <= 32'd1; lvl1_m <= 32'd1; lvl2_m <= 32'd2; lvl3_m <= 32'd4; lvl4_m <= 32'd8;
            outcome_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_KEY_LOW:    key_lo <= i_cfg_data;
                    REG_KEY_HIGH:   key_hi <= i_cfg_data;
                    REG_BASELINE:   base_m <= i_cfg_data[31:0];
                    REG_LEVEL_ONE:  lvl1_m <= i_cfg_data[31:0];
                    REG_LEVEL_TWO:  lvl2_m <= i_cfg_data[31:0];
                    REG_LEVEL_THR:  lvl3_m <= i_cfg_data[31:0];
                    REG_LEVEL_FOUR: lvl4_m <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                outcome_q.push_back(predict_outcome());
            if (o_valid && !i_stall) begin
                if (outcome_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result caps=%h tag=%h level=%h status=%b",
                                 o_offer_caps, o_offer_tag, o_agreed_level, o_status);
                    o_errors <= o_errors + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (want.caps !== o_offer_caps || want.tag !== o_offer_tag ||
                        want.level !== o_agreed_level || want.status !== o_status) begin
                        if (o_errors < 10)
                            $display({"mismatch exp caps=%h tag=%h level=%h status=%b",
                                      " act caps=%h tag=%h level=%h status=%b"},
                                     want.caps, want.tag, want.level, want.status,
                                     o_offer_caps, o_offer_tag, o_agreed_level, o_status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= outcome_q.size();
        end
    end
endmodule

>>> tb/tb_mac_checked_capability_negotiator.sv
// Stimulus and verdict for the capability negotiator, checked by mccn_checker.
module tb_mac_checked_capability_negotiator;
    timeunit 1ns;
    timeprecision 1ps;
    import mccn_pkg::*;
    import mccn_tb_pkg::*;

    localparam logic [2:0] REG_NONE = 3'd7;
    localparam logic [1:0] ACT_NONE = 2'd3;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall;
    logic [1:0]  i_action;
    logic [31:0] i_local_caps, i_remote_caps;
    logic [63:0] i_local_tag, i_remote_tag;
    logic        o_valid, i_stall;
    logic [31:0] o_offer_caps, o_agreed_level;
    logic [63:0] o_offer_tag;
    logic        o_status;
    logic        i_cfg_valid, o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    int          errors, pending;

    int          idle_pct, stall_pct;
    bit          hold_req;
    logic [63:0] key_lo, key_hi;

    mac_checked_capability_negotiator u_top (.*);

    mccn_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_action, .i_local_caps, .i_local_tag,
        .i_remote_caps, .i_remote_tag, .o_valid, .i_stall, .o_offer_caps, .o_offer_tag,
        .o_agreed_level, .o_status, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = 80;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [31:0] lc, input logic [63:0] lt,
                             input logic [31:0] rc, input logic [63:0] rt);
        bit taken;
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_local_caps <= lc;
        i_local_tag <= lt;
        i_remote_caps <= rc;
        i_remote_tag <= rt;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_KEY_LOW) key_lo = val;
        if (idx == REG_KEY_HIGH) key_hi = val;
    endtask

    task automatic load_regs(input logic [63:0] klo, input logic [63:0] khi,
                             input logic [31:0] b, input logic [31:0] l1, input logic [31:0] l2,
                             input logic [31:0] l3, input logic [31:0] l4);
        write_reg(REG_KEY_LOW, klo);
        write_reg(REG_KEY_HIGH, khi);
        write_reg(REG_BASELINE, {$urandom, b});
        write_reg(REG_LEVEL_ONE, {32'h0, l1});
        write_reg(REG_LEVEL_TWO, {32'h0, l2});
        write_reg(REG_LEVEL_THR, {32'h0, l3});
        write_reg(REG_LEVEL_FOUR, {32'h0, l4});
    endtask

    function automatic logic [31:0] rnd_caps();
        case ($urandom_range(3))
            0: return $urandom_range(15);
            1: return 32'hffffffff ^ (32'h1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random();
        logic [1:0]  act;
        logic [31:0] lc, rc;
        logic [63:0] lt, rt;
        int          pick;
        pick = $urandom_range(99);
        act = (pick < 20) ? ACT_MAKE : (pick < 40) ? ACT_VERIFY :
              (pick < 95) ? ACT_RESOLVE : ACT_NONE;
        lc = rnd_caps();
        rc = rnd_caps();
        lt = ($urandom_range(9) < 8) ? caps_sip_tag(key_lo, key_hi, lc) : rnd64();
        rt = ($urandom_range(9) < 8) ? caps_sip_tag(key_lo, key_hi, rc) : rnd64();
        send_item(act, lc, lt, rc, rt);
    endtask

    task automatic directed_set();
        logic [63:0] t0, tf;
        t0 = caps_sip_tag(key_lo, key_hi, 32'h0);
        tf = caps_sip_tag(key_lo, key_hi, 32'hffffffff);
        send_item(ACT_MAKE, 32'h0, 64'h0, 32'h0, 64'h0);
        send_item(ACT_MAKE, 32'hffffffff, '1, 32'hffffffff, '1);
        send_item(ACT_VERIFY, 32'h0, t0, 32'h0, 64'h0);
        send_item(ACT_VERIFY, 32'hffffffff, tf, 32'h0, 64'h0);
        send_item(ACT_VERIFY, 32'hffffffff, ~tf, 32'h0, 64'h0);
        send_item(ACT_RESOLVE, 32'hffffffff, tf, 32'hffffffff, tf);
        send_item(ACT_RESOLVE, 32'h0, t0, 32'hffffffff, tf);
        send_item(ACT_RESOLVE, 32'h7, caps_sip_tag(key_lo, key_hi, 32'h7),
                  32'h5, caps_sip_tag(key_lo, key_hi, 32'h5));
        send_item(ACT_RESOLVE, 32'h3, caps_sip_tag(key_lo, key_hi, 32'h3),
                  32'hb, caps_sip_tag(key_lo, key_hi, 32'hb));
        send_item(ACT_RESOLVE, 32'h1, caps_sip_tag(key_lo, key_hi, 32'h1),
                  32'hf, caps_sip_tag(key_lo, key_hi, 32'hf));
        send_item(ACT_RESOLVE, 32'he, caps_sip_tag(key_lo, key_hi, 32'he),
                  32'hf, caps_sip_tag(key_lo, key_hi, 32'hf));
        send_item(ACT_RESOLVE, 32'hffffffff, tf ^ 64'h1, 32'hffffffff, tf);
        send_item(ACT_RESOLVE, 32'hffffffff, tf, 32'hffffffff, ~tf);
        send_item(ACT_NONE, 32'hffffffff, '1, 32'hffffffff, '1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = ACT_MAKE;
        i_local_caps = '0; i_local_tag = '0;
        i_remote_caps = '0; i_remote_tag = '0;
        i_cfg_valid = 1'b0; i_cfg_index = REG_KEY_LOW; i_cfg_data = '0;
        idle_pct = 0; stall_pct = 0; hold_req = 1'b0;
        key_lo = '0; key_hi = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_set();
        drain();
        load_regs('1, '1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        write_reg(REG_NONE, '1);
        directed_set();
        drain();
        load_regs('0, '1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        directed_set();
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            idle_pct = (ph == 1 || ph == 4) ? 48 : (ph == 3) ? 23 : 0;
            stall_pct = (ph == 2 || ph == 4) ? 48 : (ph == 3) ? 23 : 0;
            load_regs(rnd64(), rnd64(), 32'h1 << $urandom_range(3), $urandom, 32'h30,
                      32'h300 | (32'h1 << $urandom_range(31)), 32'hc000_0000);
            if (ph == 0)
                hold_req = 1'b1;
            for (int k = 0; k < 100; k++) begin
                send_random();
                if (ph == 3 && k == 50) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
